FILE: rtl/rsf_pkg.sv
`timescale 1ns / 1ps

package rsf_pkg;

    localparam int MAX_LEN_DEF   = 256;
    localparam int MAX_STEMS_DEF = 64;

    localparam logic [3:0] GAP_RESET = 4'd4;

    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_U = 3'd3;

    // start, end, length of one recorded stem, 8 bits each
    localparam int RES_W = 24;

    typedef struct packed {
        logic [2:0] base_code;
        logic       last_base;
    } in_item_t;

    typedef struct packed {
        logic [7:0] stem_start;
        logic [7:0] stem_end;
        logic [7:0] stem_length;
        logic       stem_valid;
        logic       stem_overflow;
        logic       last_stem;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PAIR_RD,
        ST_PAIR_CHK,
        ST_EXT_RD,
        ST_EXT_CHK,
        ST_END_RUN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    // Watson-Crick plus the GU wobble, either orientation
    function automatic logic bonds(input logic [2:0] a, input logic [2:0] b);
        logic res;
        begin
            res = ((a == BASE_A) && (b == BASE_U)) || ((a == BASE_U) && (b == BASE_A)) ||
                  ((a == BASE_G) && (b == BASE_C)) || ((a == BASE_C) && (b == BASE_G)) ||
                  ((a == BASE_G) && (b == BASE_U)) || ((a == BASE_U) && (b == BASE_G));
            return res;
        end
    endfunction

endpackage

FILE: rtl/rsf_ram.sv
`timescale 1ns / 1ps

module rsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                         rdata_a,
    output logic [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/rna_stem_finder.sv
`timescale 1ns / 1ps

// RNA stem finder. Bases load one per cycle into the base store while it
// is in its load state. The item flagged last_base starts a scan of every
// pair i<j with j-i >= min_loop_gap (0 counts as 1), in ascending i then j.
// The store has two registered read ports, so each candidate pair takes a
// read state and then a compare state, and each inward extension step
// does the same. A bonding pair also pays for the probe that ends its run
// (a read state alone when the gap rule stops it, a read and a compare when
// the inner bases fail to pair) and one state to close it. No input is
// taken during the scan. Stems of two or more stacked pairs go into a
// result buffer of MAX_STEMS entries; overflow is only known once the scan
// ends, so results are released afterwards, each read from the buffer only
// after the previous one is taken.
// A scan without stems gives one empty result flagged last_stem. After the
// final result is taken the block is ready for the next sequence.
module rna_stem_finder #(
    parameter int MAX_LEN   = rsf_pkg::MAX_LEN_DEF,
    parameter int MAX_STEMS = rsf_pkg::MAX_STEMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsf_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rsf_pkg::out_item_t out_data,
    input  logic               cfg_write_en,
    input  logic [3:0]         cfg_write_data
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int SW = $clog2(MAX_LEN + 16);
    localparam int CW = $clog2(MAX_STEMS + 1);
    localparam int RW = (MAX_STEMS > 1) ? $clog2(MAX_STEMS) : 1;

    rsf_pkg::state_t    state_reg, state_next;
    logic [3:0]         gap_cfg_reg;
    logic [LW-1:0]      seq_len_reg, seq_len_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               ovf_reg, ovf_next;
    logic [SW-1:0]      i_reg, i_next;
    logic [SW-1:0]      j_reg, j_next;
    logic [SW-1:0]      lo_reg, lo_next;
    logic [SW-1:0]      hi_reg, hi_next;
    logic [SW-1:0]      len_reg, len_next;
    logic               out_valid_reg, out_valid_next;
    rsf_pkg::out_item_t out_reg, out_next;

    logic [SW-1:0]      gap;
    logic [SW-1:0]      seq_n;
    logic [SW-1:0]      adv_i, adv_j;
    logic               scan_end, ext_room, pair_bond;
    logic               in_acc, out_acc;

    logic               base_we;
    logic [AW-1:0]      base_waddr, base_raddr_a, base_raddr_b;
    logic [2:0]         base_rd_a, base_rd_b;
    logic               res_we;
    logic [RW-1:0]      res_waddr, res_raddr;
    logic [rsf_pkg::RES_W-1:0] res_wdata, res_rdata;

    rsf_ram #(
        .WIDTH (3),
        .DEPTH (MAX_LEN)
    ) u_base_store (
        .clk     (clk),
        .we      (base_we),
        .waddr   (base_waddr),
        .wdata   (in_data.base_code),
        .raddr_a (base_raddr_a),
        .raddr_b (base_raddr_b),
        .rdata_a (base_rd_a),
        .rdata_b (base_rd_b)
    );

    rsf_ram #(
        .WIDTH (rsf_pkg::RES_W),
        .DEPTH (MAX_STEMS)
    ) u_result_buf (
        .clk     (clk),
        .we      (res_we),
        .waddr   (res_waddr),
        .wdata   (res_wdata),
        .raddr_a (res_raddr),
        .raddr_b (res_raddr),
        .rdata_a (res_rdata),
        .rdata_b ()
    );

    always_comb
    begin
        gap       = (gap_cfg_reg == 4'd0) ? SW'(1) : SW'(gap_cfg_reg);
        seq_n     = SW'(seq_len_reg);
        scan_end  = (i_reg + gap) >= seq_n;
        ext_room  = hi_reg >= (lo_reg + gap);
        pair_bond = rsf_pkg::bonds(base_rd_a, base_rd_b);
        in_acc    = in_valid && in_ready;
        out_acc   = out_valid && out_ready;
        // step to the next (i, j) in scan order
        if ((j_reg + SW'(1)) >= seq_n)
        begin
            adv_i = i_reg + SW'(1);
            adv_j = i_reg + SW'(1) + gap;
        end
        else
        begin
            adv_i = i_reg;
            adv_j = j_reg + SW'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsf_pkg::ST_LOAD:
            begin
                if (in_acc && in_data.last_base)
                begin
                    state_next = rsf_pkg::ST_PAIR_RD;
                end
            end
            rsf_pkg::ST_PAIR_RD:
            begin
                if (!scan_end)
                begin
                    state_next = rsf_pkg::ST_PAIR_CHK;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = rsf_pkg::ST_EMIT_WAIT;
                end
                else
                begin
                    state_next = rsf_pkg::ST_EMIT_RD;
                end
            end
            rsf_pkg::ST_PAIR_CHK:
            begin
                state_next = pair_bond ? rsf_pkg::ST_EXT_RD : rsf_pkg::ST_PAIR_RD;
            end
            rsf_pkg::ST_EXT_RD:
            begin
                state_next = ext_room ? rsf_pkg::ST_EXT_CHK : rsf_pkg::ST_END_RUN;
            end
            rsf_pkg::ST_EXT_CHK:
            begin
                state_next = pair_bond ? rsf_pkg::ST_EXT_RD : rsf_pkg::ST_END_RUN;
            end
            rsf_pkg::ST_END_RUN:
            begin
                state_next = rsf_pkg::ST_PAIR_RD;
            end
            rsf_pkg::ST_EMIT_RD:
            begin
                state_next = rsf_pkg::ST_EMIT_LD;
            end
            rsf_pkg::ST_EMIT_LD:
            begin
                state_next = rsf_pkg::ST_EMIT_WAIT;
            end
            rsf_pkg::ST_EMIT_WAIT:
            begin
                if (out_acc)
                begin
                    state_next = out_reg.last_stem ? rsf_pkg::ST_LOAD : rsf_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = rsf_pkg::ST_LOAD;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        seq_len_next   = seq_len_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        in_ready     = (state_reg == rsf_pkg::ST_LOAD);
        base_we      = 1'b0;
        base_waddr   = seq_len_reg[AW-1:0];
        base_raddr_a = i_reg[AW-1:0];
        base_raddr_b = j_reg[AW-1:0];
        res_we       = 1'b0;
        res_waddr    = cnt_reg[RW-1:0];
        res_wdata    = {8'(i_reg), 8'(j_reg), 8'(len_reg)};
        res_raddr    = k_reg[RW-1:0];

        unique case (state_reg)
            rsf_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    // bases past the end of the store are dropped
                    if (seq_len_reg < LW'(MAX_LEN))
                    begin
                        base_we      = 1'b1;
                        seq_len_next = seq_len_reg + LW'(1);
                    end
                    i_next   = '0;
                    j_next   = gap;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            rsf_pkg::ST_PAIR_RD:
            begin
                if (scan_end)
                begin
                    k_next = '0;
                    if (cnt_reg == '0)
                    begin
                        out_valid_next         = 1'b1;
                        out_next               = '0;
                        out_next.last_stem     = 1'b1;
                    end
                end
            end
            rsf_pkg::ST_PAIR_CHK:
            begin
                if (pair_bond)
                begin
                    lo_next  = i_reg + SW'(1);
                    hi_next  = j_reg - SW'(1);
                    len_next = SW'(1);
                end
                else
                begin
                    i_next = adv_i;
                    j_next = adv_j;
                end
            end
            rsf_pkg::ST_EXT_RD:
            begin
                base_raddr_a = lo_reg[AW-1:0];
                base_raddr_b = hi_reg[AW-1:0];
            end
            rsf_pkg::ST_EXT_CHK:
            begin
                if (pair_bond)
                begin
                    len_next = len_reg + SW'(1);
                    lo_next  = lo_reg + SW'(1);
                    hi_next  = hi_reg - SW'(1);
                end
            end
            rsf_pkg::ST_END_RUN:
            begin
                if (len_reg >= SW'(2))
                begin
                    if (cnt_reg < CW'(MAX_STEMS))
                    begin
                        res_we   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                i_next = adv_i;
                j_next = adv_j;
            end
            rsf_pkg::ST_EMIT_RD:
            begin
                res_raddr = k_reg[RW-1:0];
            end
            rsf_pkg::ST_EMIT_LD:
            begin
                out_valid_next         = 1'b1;
                out_next.stem_start    = res_rdata[23:16];
                out_next.stem_end      = res_rdata[15:8];
                out_next.stem_length   = res_rdata[7:0];
                out_next.stem_valid    = 1'b1;
                out_next.stem_overflow = ovf_reg;
                out_next.last_stem     = (k_reg == (cnt_reg - CW'(1)));
            end
            rsf_pkg::ST_EMIT_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    k_next         = k_reg + CW'(1);
                    if (out_reg.last_stem)
                    begin
                        seq_len_next = '0;
                        cnt_next     = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsf_pkg::ST_LOAD;
            gap_cfg_reg   <= rsf_pkg::GAP_RESET;
            seq_len_reg   <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_len_reg   <= seq_len_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                gap_cfg_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        len_reg <= len_next;
        out_reg <= out_next;
    end

    // loading and emitting never overlap
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(MAX_STEMS))
        else $error("stem count beyond buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_we |-> (cnt_reg < CW'(MAX_STEMS)) && (len_reg >= SW'(2)))
        else $error("result buffer written out of range or with a short run");

    // inner reads only ever happen inside the gap rule
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsf_pkg::ST_EXT_CHK) |-> (hi_reg >= lo_reg + gap))
        else $error("extension read broke the gap rule");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_data.last_stem) |=> (seq_len_reg == '0) && in_ready && !out_valid)
        else $error("block not rearmed after final result");

endmodule
